// File: rtl/spi_angle_read_sequencer_unit_macros.svh
// ---------------------------------------------------------------------------
// spi angle read sequencer assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef SPI_ANGLE_READ_SEQUENCER_UNIT_MACROS_SVH
`define SPI_ANGLE_READ_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication
`define SARS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sars same-cycle check failed");

// next-cycle implication
`define SARS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sars next-cycle check failed");

`endif

// File: rtl/sars_pkg.sv
// ---------------------------------------------------------------------------
// sars_pkg
// shared constants, types and frame helpers of the spi angle read sequencer
// ---------------------------------------------------------------------------
package sars_pkg;

  localparam int FRAME_BITS = 16;
  localparam int CNT_W      = 16;
  localparam int NUM_CNT    = 6;
  localparam int CFG_AW     = 5;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_RESP  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_FRAME   = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_CLEARED = 2'd2;

  // counter slots
  localparam int CNT_PARITY = 0;
  localparam int CNT_SENSOR = 1;
  localparam int CNT_CLEARS = 2;
  localparam int CNT_CLRPAR = 3;
  localparam int CNT_GOODRT = 4;
  localparam int CNT_FAILED = 5;

  // register indexes
  localparam logic [2:0] REG_RESOLUTION = 3'd0;
  localparam logic [2:0] REG_DATA_TOP   = 3'd1;
  localparam logic [2:0] REG_READ_FLAG  = 3'd2;
  localparam logic [2:0] REG_PAR_FLAG   = 3'd3;
  localparam logic [2:0] REG_CHECK_PAR  = 3'd4;
  localparam logic [2:0] REG_ERR_FLAG   = 3'd5;
  localparam logic [2:0] REG_CLEAR_ADDR = 3'd6;
  localparam logic [2:0] REG_RETRY      = 3'd7;

  typedef logic [NUM_CNT-1:0][CNT_W-1:0] cnt_arr_t;

  typedef struct packed {
    logic               clear;
    logic [NUM_CNT-1:0] bump;
  } cnt_ctl_t;

  // even parity over a whole frame
  function automatic logic parity16(input logic [FRAME_BITS-1:0] v);
    return ^v;
  endfunction

  // command frame: address, optional read bit, optional parity bit
  function automatic logic [FRAME_BITS-1:0] build_command(
    input logic [FRAME_BITS-1:0] addr,
    input logic [3:0]            rd_bit,
    input logic [3:0]            par_bit
  );
    logic [FRAME_BITS-1:0] c;
    c = addr;
    if (rd_bit != 4'd0) c[rd_bit] = 1'b1;
    if (par_bit != 4'd0) c[par_bit] = c[par_bit] | parity16(c);
    return c;
  endfunction

  // shifted and masked data field of a response
  function automatic logic [FRAME_BITS-1:0] extract(
    input logic [FRAME_BITS-1:0] w,
    input logic [4:0]            res_bits,
    input logic [3:0]            top_bit
  );
    logic [4:0]            res;
    logic [4:0]            top1;
    logic [4:0]            sh;
    logic [FRAME_BITS-1:0] mask;
    res  = (res_bits > 5'd16) ? 5'd16 : res_bits;
    mask = (res == 5'd0) ? '0 : (16'hFFFF >> (5'd16 - res));
    top1 = {1'b0, top_bit} + 5'd1;
    sh   = (top1 > res) ? (top1 - res) : 5'd0;
    return (w >> sh) & mask;
  endfunction

endpackage

// File: rtl/sars_if.sv
// ---------------------------------------------------------------------------
// sars channel interfaces
// valid/ready channels for request items and result items
// ---------------------------------------------------------------------------
interface sars_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [13:0] reg_address;
  logic [15:0] response_word;

  modport source (output valid, opcode, reg_address, response_word, input ready);
  modport sink   (input valid, opcode, reg_address, response_word, output ready);
endinterface

interface sars_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic [15:0]        frame_word;
  logic signed [16:0] count_value;
  logic [1:0]         status_flags;
  logic [15:0]        error_detail;
  logic [15:0]        parity_errors;
  logic [15:0]        sensor_errors;
  logic [15:0]        clear_reads;
  logic [15:0]        clear_parity_errors;
  logic [15:0]        good_retries;
  logic [15:0]        failed_reads;

  modport source (
    output valid, result_kind, frame_word, count_value, status_flags, error_detail,
           parity_errors, sensor_errors, clear_reads, clear_parity_errors,
           good_retries, failed_reads,
    input  ready
  );
  modport sink (
    input  valid, result_kind, frame_word, count_value, status_flags, error_detail,
           parity_errors, sensor_errors, clear_reads, clear_parity_errors,
           good_retries, failed_reads,
    output ready
  );
endinterface

// File: rtl/sars_err_counters.sv
// ---------------------------------------------------------------------------
// sars_err_counters
// six saturating error counters with a common clear
// ---------------------------------------------------------------------------
module sars_err_counters (
  input  logic              clk,
  input  logic              rst_n,
  input  sars_pkg::cnt_ctl_t ctl,
  output sars_pkg::cnt_arr_t cnt_r,
  output sars_pkg::cnt_arr_t cnt_nxt
);

  always_comb begin
    for (int i = 0; i < sars_pkg::NUM_CNT; i++) begin
      if (ctl.clear) begin
        cnt_nxt[i] = '0;
      end else if (ctl.bump[i] && (cnt_r[i] < sars_pkg::CNT_MAX)) begin
        cnt_nxt[i] = cnt_r[i] + 1'b1;
      end else begin
        cnt_nxt[i] = cnt_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/spi_angle_read_sequencer_unit.sv
// ---------------------------------------------------------------------------
// spi_angle_read_sequencer_unit
// sequences sensor register reads one spi frame at a time, checks parity and
// the sensor error bit, issues error-clear reads and retries
// ---------------------------------------------------------------------------
//  channel   dir  handshake        carries
//  in_ch     in   valid/ready      opcode, reg_address, response_word
//  out_ch    out  valid/ready      result kind, frame, count, status, counters
//  apb       in   psel/penable     eight config registers at 4*index
//
//  one transfer per cycle sustained while out_ch is not stalled: an input
//  register, decode and state update, then the result register; an item
//  is registered in stage one, then in the result register that drives out_ch.valid
//  synchronous active-low reset restores register defaults and clears state
//  a stalled result holds stage one; in_ch.ready drops only while stage one
//  is full and the result register cannot be replaced
// ---------------------------------------------------------------------------
`include "spi_angle_read_sequencer_unit_macros.svh"

module spi_angle_read_sequencer_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  sars_in_if.sink                    in_ch,
  sars_out_if.source                 out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sars_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ANGLE = 2'd1;
  localparam logic [1:0] PH_CLEAR = 2'd2;

  // ---------------- configuration registers ----------------
  logic [4:0]  resolution_r;
  logic [3:0]  data_top_r;
  logic [3:0]  read_flag_r;
  logic [3:0]  par_flag_r;
  logic        check_par_r;
  logic [3:0]  err_flag_r;
  logic [15:0] clear_addr_r;
  logic [7:0]  retry_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resolution_r <= 5'd14;
      data_top_r   <= 4'd13;
      read_flag_r  <= 4'd14;
      par_flag_r   <= 4'd15;
      check_par_r  <= 1'b0;
      err_flag_r   <= 4'd0;
      clear_addr_r <= 16'd0;
      retry_r      <= 8'd0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sars_pkg::REG_RESOLUTION: resolution_r <= pwdata[4:0];
        sars_pkg::REG_DATA_TOP:   data_top_r   <= pwdata[3:0];
        sars_pkg::REG_READ_FLAG:  read_flag_r  <= pwdata[3:0];
        sars_pkg::REG_PAR_FLAG:   par_flag_r   <= pwdata[3:0];
        sars_pkg::REG_CHECK_PAR:  check_par_r  <= pwdata[0];
        sars_pkg::REG_ERR_FLAG:   err_flag_r   <= pwdata[3:0];
        sars_pkg::REG_CLEAR_ADDR: clear_addr_r <= pwdata[15:0];
        sars_pkg::REG_RETRY:      retry_r      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      sars_pkg::REG_RESOLUTION: prdata = {27'd0, resolution_r};
      sars_pkg::REG_DATA_TOP:   prdata = {28'd0, data_top_r};
      sars_pkg::REG_READ_FLAG:  prdata = {28'd0, read_flag_r};
      sars_pkg::REG_PAR_FLAG:   prdata = {28'd0, par_flag_r};
      sars_pkg::REG_CHECK_PAR:  prdata = {31'd0, check_par_r};
      sars_pkg::REG_ERR_FLAG:   prdata = {28'd0, err_flag_r};
      sars_pkg::REG_CLEAR_ADDR: prdata = {16'd0, clear_addr_r};
      sars_pkg::REG_RETRY:      prdata = {24'd0, retry_r};
      default:                  prdata = '0;
    endcase
  end

  // ---------------- stage one: input register ----------------
  logic        s1_valid_r;
  logic [1:0]  s1_op_r;
  logic [13:0] s1_addr_r;
  logic [15:0] s1_word_r;
  logic        fire1;   // stage one item is processed this cycle
  logic        out_valid_r;

  // the item leaves stage one whenever the result register is free or draining
  assign fire1       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || fire1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op_r   <= in_ch.opcode;
      s1_addr_r <= in_ch.reg_address;
      s1_word_r <= in_ch.response_word;
    end
  end

  // ---------------- sequencer state ----------------
  logic [1:0]  phase_r,      phase_nxt;
  logic [15:0] angle_cmd_r,  angle_cmd_nxt;
  logic [8:0]  attempt_r,    attempt_nxt;
  logic [1:0]  acc_status_r, acc_status_nxt;
  logic [15:0] valid_cnt_r,  valid_cnt_nxt;
  logic        has_valid_r,  has_valid_nxt;
  logic [15:0] detail_r,     detail_nxt;

  sars_pkg::cnt_ctl_t cnt_ctl;
  sars_pkg::cnt_arr_t cnt_r;
  sars_pkg::cnt_arr_t cnt_nxt;

  // result of the current item
  logic        produce;
  logic [1:0]  res_kind;
  logic [15:0] res_frame;
  logic [1:0]  res_status;

  // response checks
  logic        validate;
  logic [8:0]  attempts;
  logic [8:0]  attempt_inc;
  logic        retry_go;
  logic        par_bad;
  logic        err_hit;
  logic [15:0] resp_data;
  logic [1:0]  acc_fail;     // status after a failed attempt on this item

  assign validate    = check_par_r || (err_flag_r != 4'd0);
  assign attempts    = validate ? ({1'b0, retry_r} + 9'd1) : 9'd1;
  assign attempt_inc = attempt_r + 9'd1;
  assign retry_go    = attempt_inc < attempts;
  assign par_bad     = check_par_r && sars_pkg::parity16(s1_word_r);
  assign err_hit     = (err_flag_r != 4'd0) && s1_word_r[err_flag_r];
  assign resp_data   = sars_pkg::extract(s1_word_r, resolution_r, data_top_r);

  always_comb begin
    phase_nxt      = phase_r;
    angle_cmd_nxt  = angle_cmd_r;
    attempt_nxt    = attempt_r;
    acc_status_nxt = acc_status_r;
    valid_cnt_nxt  = valid_cnt_r;
    has_valid_nxt  = has_valid_r;
    detail_nxt     = detail_r;
    cnt_ctl        = '0;
    produce        = 1'b0;
    res_kind       = sars_pkg::KIND_FRAME;
    res_frame      = '0;
    res_status     = '0;
    acc_fail       = acc_status_r;
    // goes with a retry or giving up; overridden where the item ends otherwise
    if (s1_valid_r) begin
      case (s1_op_r)
        sars_pkg::OP_START: begin
          angle_cmd_nxt  = sars_pkg::build_command({2'b00, s1_addr_r},
                                                   read_flag_r, par_flag_r);
          attempt_nxt    = '0;
          acc_status_nxt = '0;
          phase_nxt      = PH_ANGLE;
          produce        = 1'b1;
          res_kind       = sars_pkg::KIND_FRAME;
          res_frame      = angle_cmd_nxt;
        end
        sars_pkg::OP_CLEAR: begin
          cnt_ctl.clear = 1'b1;
          produce       = 1'b1;
          res_kind      = sars_pkg::KIND_CLEARED;
          res_status    = acc_status_r;
        end
        sars_pkg::OP_RESP: begin
          if (phase_r != PH_IDLE) begin
            produce = 1'b1;
            // default outcome: next attempt or give up
            if (phase_r == PH_CLEAR) begin
              if (par_bad) begin
                cnt_ctl.bump[sars_pkg::CNT_PARITY] = 1'b1;
                cnt_ctl.bump[sars_pkg::CNT_CLRPAR] = 1'b1;
                acc_fail = acc_status_r | 2'b01;
              end else begin
                detail_nxt = resp_data;
              end
            end else if (par_bad) begin
              cnt_ctl.bump[sars_pkg::CNT_PARITY] = 1'b1;
              acc_fail = acc_status_r | 2'b01;
            end else if (err_hit) begin
              cnt_ctl.bump[sars_pkg::CNT_SENSOR] = 1'b1;
              acc_fail = acc_status_r | 2'b10;
            end
            acc_status_nxt = acc_fail;
            attempt_nxt    = attempt_inc;
            if (retry_go) begin
              phase_nxt = PH_ANGLE;
              res_kind  = sars_pkg::KIND_FRAME;
              res_frame = angle_cmd_r;
            end else begin
              cnt_ctl.bump[sars_pkg::CNT_FAILED] = 1'b1;
              phase_nxt = PH_IDLE;
              res_kind  = sars_pkg::KIND_DONE;
            end
            res_status = acc_fail;

            // angle response outcomes that replace the retry path
            if (phase_r == PH_ANGLE && !par_bad) begin
              if (err_hit && (clear_addr_r != 16'd0)) begin
                // sensor error: issue the error-clear read
                cnt_ctl.bump[sars_pkg::CNT_FAILED] = 1'b0;
                cnt_ctl.bump[sars_pkg::CNT_CLEARS] = 1'b1;
                attempt_nxt = attempt_r;
                phase_nxt   = PH_CLEAR;
                res_kind    = sars_pkg::KIND_FRAME;
                res_frame   = sars_pkg::build_command(clear_addr_r,
                                                      read_flag_r, par_flag_r);
              end else if (!err_hit) begin
                // good reading
                cnt_ctl.bump[sars_pkg::CNT_FAILED] = 1'b0;
                cnt_ctl.bump[sars_pkg::CNT_GOODRT] = (attempt_r != 9'd0);
                attempt_nxt    = attempt_r;
                valid_cnt_nxt  = resp_data;
                has_valid_nxt  = 1'b1;
                phase_nxt      = PH_IDLE;
                acc_status_nxt = '0;
                res_kind       = sars_pkg::KIND_DONE;
                res_frame      = '0;
                res_status     = '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
    // nothing moves unless the item is really processed
    if (!fire1) cnt_ctl = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      angle_cmd_r  <= '0;
      attempt_r    <= '0;
      acc_status_r <= '0;
      valid_cnt_r  <= '0;
      has_valid_r  <= 1'b0;
      detail_r     <= '0;
    end else if (fire1) begin
      phase_r      <= phase_nxt;
      angle_cmd_r  <= angle_cmd_nxt;
      attempt_r    <= attempt_nxt;
      acc_status_r <= acc_status_nxt;
      valid_cnt_r  <= valid_cnt_nxt;
      has_valid_r  <= has_valid_nxt;
      detail_r     <= detail_nxt;
    end
  end

  sars_err_counters u_counters (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cnt_ctl),
    .cnt_r   (cnt_r),
    .cnt_nxt (cnt_nxt)
  );

  // ---------------- result register ----------------
  logic [1:0]         out_kind_r;
  logic [15:0]        out_frame_r;
  logic signed [16:0] out_count_r;
  logic [1:0]         out_status_r;
  logic [15:0]        out_detail_r;
  sars_pkg::cnt_arr_t out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire1) begin
      out_valid_r <= produce;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire1 && produce) begin
      out_kind_r   <= res_kind;
      out_frame_r  <= res_frame;
      // minus one until a reading has ever been good
      out_count_r  <= has_valid_nxt ? $signed({1'b0, valid_cnt_nxt}) : -17'sd1;
      out_status_r <= res_status;
      out_detail_r <= detail_nxt;
      out_cnt_r    <= cnt_nxt;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.result_kind         = out_kind_r;
  assign out_ch.frame_word          = out_frame_r;
  assign out_ch.count_value         = out_count_r;
  assign out_ch.status_flags        = out_status_r;
  assign out_ch.error_detail        = out_detail_r;
  assign out_ch.parity_errors       = out_cnt_r[sars_pkg::CNT_PARITY];
  assign out_ch.sensor_errors       = out_cnt_r[sars_pkg::CNT_SENSOR];
  assign out_ch.clear_reads         = out_cnt_r[sars_pkg::CNT_CLEARS];
  assign out_ch.clear_parity_errors = out_cnt_r[sars_pkg::CNT_CLRPAR];
  assign out_ch.good_retries        = out_cnt_r[sars_pkg::CNT_GOODRT];
  assign out_ch.failed_reads        = out_cnt_r[sars_pkg::CNT_FAILED];

  // ---------------- assertions ----------------
  `SARS_ASSERT_NXT(a_done_goes_idle, fire1 && produce && (res_kind == sars_pkg::KIND_DONE), phase_r == PH_IDLE)
  `SARS_ASSERT_NXT(a_clear_zeroes, fire1 && (s1_op_r == sars_pkg::OP_CLEAR), cnt_r == '0)
  `SARS_ASSERT_IMP(a_stall_blocks_input, s1_valid_r && out_valid_r && !out_ch.ready, !in_ch.ready)

endmodule
